// ----- rtl/motion_ctrl_response_deframer_core_assert.svh -----
// assertion macros for the reply deframer checker
// expects signals named clk and rst_n in the scope of use
`ifndef MOTION_CTRL_RESPONSE_DEFRAMER_CORE_ASSERT_SVH
`define MOTION_CTRL_RESPONSE_DEFRAMER_CORE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MCRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mcrd_pkg.sv -----
// shared types, codes and tables of the motion controller reply deframer
// no dependencies
package mcrd_pkg;

    typedef logic [3:0] status_t;

    localparam status_t STATUS_OK       = 4'd0;
    localparam status_t STATUS_FAILED   = 4'd1;
    localparam status_t STATUS_DENIED   = 4'd2;
    localparam status_t STATUS_PASSWORD = 4'd3;
    localparam status_t STATUS_IO       = 4'd4;
    localparam status_t STATUS_ILLEGAL  = 4'd5;
    localparam status_t STATUS_LIMIT    = 4'd6;
    localparam status_t STATUS_DEVICE   = 4'd7;
    localparam status_t STATUS_OVERFLOW = 4'd8;

    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_BELL  = 8'h07;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_REPORT_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_LIMIT    = 1'b1;

    localparam logic [1:0]  MODE_ERR_TEXT  = 2'd1;
    localparam logic [1:0]  MODE_RESET     = 2'd0;
    localparam logic [11:0] LIMIT_RESET    = 12'd80;
    localparam logic [11:0] LIMIT_MIN      = 12'd2;
    localparam logic [9:0]  NUM_MAX        = 10'd1023;
    localparam logic [9:0]  NUM_CLASSES    = 10'd20;
    localparam logic [1:0]  PREFIX_LEN     = 2'd3;

    // per-reply parse state
    typedef struct packed {
        logic [11:0] byte_count;
        logic        first_was_bell;
        logic        bell_seen;
        logic [1:0]  prefix_matched;
        logic        prefix_bad;
        logic        digit_seen;
        logic        number_done;
        logic [9:0]  number_acc;
        logic [7:0]  held_byte;
        logic        held_valid;
    } reply_state_t;

    // letters of the error text prefix
    function automatic logic [7:0] prefix_letter(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_E;
            default: ch = CH_R;
        endcase
        return ch;
    endfunction

    // controller error number to status class
    function automatic status_t error_class(input logic [9:0] num);
        status_t st;
        if (num >= NUM_CLASSES) begin
            st = STATUS_FAILED;
        end
        else begin
            unique case (num[4:0])
                5'd0:    st = STATUS_FAILED;
                5'd1:    st = STATUS_DENIED;
                5'd2:    st = STATUS_PASSWORD;
                5'd3:    st = STATUS_FAILED;
                5'd4:    st = STATUS_IO;
                5'd5:    st = STATUS_DENIED;
                5'd6:    st = STATUS_DENIED;
                5'd7:    st = STATUS_DENIED;
                5'd8:    st = STATUS_IO;
                5'd9:    st = STATUS_ILLEGAL;
                5'd10:   st = STATUS_LIMIT;
                5'd11:   st = STATUS_DEVICE;
                5'd12:   st = STATUS_DEVICE;
                5'd13:   st = STATUS_DEVICE;
                5'd14:   st = STATUS_ILLEGAL;
                5'd15:   st = STATUS_ILLEGAL;
                5'd16:   st = STATUS_ILLEGAL;
                5'd17:   st = STATUS_DEVICE;
                5'd18:   st = STATUS_DENIED;
                5'd19:   st = STATUS_DENIED;
                default: st = STATUS_FAILED;
            endcase
        end
        return st;
    endfunction

endpackage

// ----- rtl/mcrd_stream_if.sv -----
// valid/ready channels of the reply deframer: received bytes in, results out
// depends on mcrd_pkg
interface mcrd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mcrd_res_if;
    logic                  valid;
    logic                  ready;
    logic                  data_valid;
    logic [7:0]            data_byte;
    logic                  reply_done;
    mcrd_pkg::status_t     status;
    logic [9:0]            error_number;

    modport source (output valid, output data_valid, output data_byte, output reply_done,
                    output status, output error_number, input ready);
    modport sink (input valid, input data_valid, input data_byte, input reply_done,
                  input status, input error_number, output ready);
endinterface

// ----- rtl/motion_ctrl_response_deframer_core.sv -----
// motion controller reply deframer: cuts received bytes into replies and classes errors
// depends on mcrd_pkg and the channel interfaces in mcrd_stream_if.sv
//
// Each received byte request gives exactly one result request. A byte is taken
// into an input register, runs through the parse logic and lands in the result
// register, where it waits until it is taken. One byte per cycle is sustained
// while results are taken: the input register moves on
// whenever the result register is empty or its result is being taken, and
// backpressure on the result side stalls the input side one register later.
// The user must write registers through cfg_we/cfg_index/cfg_wdata only while
// no byte is in flight; the block itself does not enforce this.
module motion_ctrl_response_deframer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mcrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mcrd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    mcrd_rx_if.sink                              rx,
    mcrd_res_if.source                           res
);

    logic [1:0]             mode_reg;
    logic [11:0]            limit_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;

    mcrd_pkg::reply_state_t state_reg;
    mcrd_pkg::reply_state_t state_next;

    logic                   out_valid_reg;
    logic                   out_dv_reg;
    logic [7:0]             out_db_reg;
    logic                   out_done_reg;
    mcrd_pkg::status_t      out_status_reg;
    logic [9:0]             out_enr_reg;

    logic                   out_dv_next;
    logic [7:0]             out_db_next;
    logic                   out_done_next;
    mcrd_pkg::status_t      out_status_next;
    logic [9:0]             out_enr_next;

    logic                   advance;
    logic                   mode1;
    logic [11:0]            limit_eff;
    logic [11:0]            limit_m1;
    logic [12:0]            count_inc;
    logic                   term;
    logic                   overflow;
    logic                   is_digit;
    logic                   is_space;
    logic [13:0]            acc_prod;
    logic [9:0]             acc_sat;
    logic                   text_bad;

    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= mcrd_pkg::MODE_RESET;
            limit_reg <= mcrd_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcrd_pkg::REG_ERROR_REPORT_MODE: mode_reg  <= cfg_wdata[1:0];
                mcrd_pkg::REG_RESPONSE_LIMIT:    limit_reg <= cfg_wdata[11:0];
                default:                         mode_reg  <= mode_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    assign mode1     = (mode_reg == mcrd_pkg::MODE_ERR_TEXT);
    assign limit_eff = (limit_reg < mcrd_pkg::LIMIT_MIN) ? mcrd_pkg::LIMIT_MIN : limit_reg;
    assign limit_m1  = limit_eff - 12'd1;
    assign count_inc = {1'b0, state_reg.byte_count} + 13'd1;
    assign overflow  = (count_inc >= {1'b0, limit_m1});

    assign term = (in_byte_reg == mcrd_pkg::CH_ACK)
               || (in_byte_reg == mcrd_pkg::CH_BELL && !mode1)
               || (in_byte_reg == mcrd_pkg::CH_CR && state_reg.bell_seen);

    assign is_digit = (in_byte_reg >= mcrd_pkg::CH_ZERO) && (in_byte_reg <= mcrd_pkg::CH_NINE);
    assign is_space = (in_byte_reg == mcrd_pkg::CH_SPACE)
                   || (in_byte_reg >= mcrd_pkg::CH_TAB && in_byte_reg <= mcrd_pkg::CH_CR);

    // decimal accumulate with saturation
    assign acc_prod = ({4'd0, state_reg.number_acc} * 14'd10)
                    + {6'd0, in_byte_reg - mcrd_pkg::CH_ZERO};
    assign acc_sat  = (acc_prod > {4'd0, mcrd_pkg::NUM_MAX}) ? mcrd_pkg::NUM_MAX : acc_prod[9:0];

    assign text_bad = state_reg.prefix_bad || (state_reg.prefix_matched != mcrd_pkg::PREFIX_LEN)
                   || !state_reg.digit_seen;

    always_comb
    begin
        state_next      = state_reg;
        out_dv_next     = state_reg.held_valid;
        out_db_next     = state_reg.held_valid ? state_reg.held_byte : 8'd0;
        out_done_next   = 1'b0;
        out_status_next = mcrd_pkg::STATUS_OK;
        out_enr_next    = 10'd0;

        if (term)
        begin
            // a cr just before the terminator is dropped
            if (state_reg.held_byte == mcrd_pkg::CH_CR)
            begin
                out_dv_next = 1'b0;
                out_db_next = 8'd0;
            end
            out_done_next = 1'b1;
            if (in_byte_reg == mcrd_pkg::CH_BELL)
            begin
                out_status_next = mcrd_pkg::STATUS_FAILED;
            end
            else if (mode1 && state_reg.first_was_bell)
            begin
                if (text_bad)
                begin
                    out_status_next = mcrd_pkg::STATUS_IO;
                end
                else
                begin
                    out_enr_next    = state_reg.number_acc;
                    out_status_next = mcrd_pkg::error_class(state_reg.number_acc);
                end
            end
            state_next = '0;
        end
        else if (overflow)
        begin
            out_done_next   = 1'b1;
            out_status_next = mcrd_pkg::STATUS_OVERFLOW;
            state_next      = '0;
        end
        else
        begin
            if (state_reg.byte_count == 12'd0 && in_byte_reg == mcrd_pkg::CH_BELL)
            begin
                state_next.first_was_bell = 1'b1;
            end
            else if (mode1 && state_reg.first_was_bell && !state_reg.prefix_bad)
            begin
                if (state_reg.prefix_matched != mcrd_pkg::PREFIX_LEN)
                begin
                    if (in_byte_reg == mcrd_pkg::prefix_letter(state_reg.prefix_matched))
                        state_next.prefix_matched = state_reg.prefix_matched + 2'd1;
                    else
                        state_next.prefix_bad = 1'b1;
                end
                else if (!state_reg.number_done)
                begin
                    if (is_digit)
                    begin
                        state_next.number_acc = acc_sat;
                        state_next.digit_seen = 1'b1;
                    end
                    // leading whitespace is skipped, anything else closes the number
                    else if (!(is_space && !state_reg.digit_seen))
                    begin
                        state_next.number_done = 1'b1;
                    end
                end
            end
            if (in_byte_reg == mcrd_pkg::CH_BELL)
            begin
                state_next.bell_seen = 1'b1;
            end
            state_next.held_byte  = in_byte_reg;
            state_next.held_valid = 1'b1;
            state_next.byte_count = count_inc[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_dv_reg     <= out_dv_next;
            out_db_reg     <= out_db_next;
            out_done_reg   <= out_done_next;
            out_status_reg <= out_status_next;
            out_enr_reg    <= out_enr_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.data_valid   = out_dv_reg;
    assign res.data_byte    = out_db_reg;
    assign res.reply_done   = out_done_reg;
    assign res.status       = out_status_reg;
    assign res.error_number = out_enr_reg;

endmodule

// ----- rtl/mcrd_checker.sv -----
// port-level checks of the reply deframer and their bind to the top level
// depends on mcrd_pkg and motion_ctrl_response_deframer_core_assert.svh
`include "motion_ctrl_response_deframer_core_assert.svh"

module mcrd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic              data_valid,
    input logic [7:0]        data_byte,
    input logic              reply_done,
    input mcrd_pkg::status_t status,
    input logic [9:0]        error_number
);

    // a stalled result keeps its payload
    `MCRD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(data_valid) && $stable(data_byte) && $stable(reply_done) && $stable(status) && $stable(error_number), "result changed while stalled")

    // status and error number only on the ending byte
    `MCRD_ASSERT(a_status_on_done, !res_valid || reply_done || (status == mcrd_pkg::STATUS_OK && error_number == 10'd0), "status without reply end")

    // no content byte shows as zero
    `MCRD_ASSERT(a_data_zero, !res_valid || data_valid || data_byte == 8'd0, "data byte without data valid")

    // a parsed error number comes with a class from the table
    `MCRD_ASSERT(a_enr_class, !res_valid || error_number == 10'd0 || (status != mcrd_pkg::STATUS_OK && status != mcrd_pkg::STATUS_OVERFLOW && status <= mcrd_pkg::STATUS_DEVICE), "error number with wrong status")

endmodule

bind motion_ctrl_response_deframer_core mcrd_checker u_mcrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .data_valid   (res.data_valid),
    .data_byte    (res.data_byte),
    .reply_done   (res.reply_done),
    .status       (res.status),
    .error_number (res.error_number)
);
